// ===== hdl/rirx_pkg.sv =====
// Shared types, widths and codes for the register IR execute unit.
package rirx_pkg;

   localparam int ACTION_W       = 4;
   localparam int RAW_IDX_W      = 5;
   localparam int VAR_IDX_W      = 8;
   localparam int VALUE_W        = 32;
   localparam int TARGET_W       = 8;
   localparam int REQ_DATA_W     = 56;
   localparam int RSP_USER_W     = 3;
   localparam int QUEUE_DEPTH    = 2;
   localparam int DEF_NUM_VARS   = 32;
   localparam int DEF_PROG_DEPTH = 256;

   typedef enum logic [ACTION_W-1:0] {
      OP_LDCONST = 4'd0,
      OP_LDVAR   = 4'd1,
      OP_ADD     = 4'd2,
      OP_SUB     = 4'd3,
      OP_STORE   = 4'd4,
      OP_STCONST = 4'd5,
      OP_OUT     = 4'd6,
      OP_HALT    = 4'd7,
      OP_LABEL   = 4'd8,
      OP_GOTO    = 4'd9,
      OP_IFLEQ   = 4'd10
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_UNDEF   = 2'd1,
      ST_HALT    = 2'd2,
      ST_STOPPED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      WR_IMM  = 2'd0,
      WR_COPY = 2'd1,
      WR_ADD  = 2'd2,
      WR_SUB  = 2'd3
   } wsel_type;

   typedef struct packed {
      logic                 need_a;
      logic                 need_b;
      logic                 wr_dest;
      wsel_type             wsel;
      logic                 is_out;
      logic                 is_halt;
      logic                 is_goto;
      logic                 is_ifleq;
      logic [VAR_IDX_W-1:0] dest;
      logic [VAR_IDX_W-1:0] src_a;
      logic [VAR_IDX_W-1:0] src_b;
      logic [VALUE_W-1:0]   imm;
      logic [TARGET_W-1:0]  target;
   } dec_type;

endpackage

// ===== hdl/register_ir_execute_unit.sv =====
// Top level of the register IR execute unit: front end, queue and back end.
//
//  Channel | Direction | Ports        | Contents
//  req     | in        | req_tdata    | decoded instruction, action in req_tuser
//  rsp     | out       | rsp_tdata    | next program counter and output value, flags in tuser
//
// When neither side stalls, one instruction word is accepted per cycle and one response word
// leaves per cycle. A response word passes from its accepted request word through the queue
// slot, the registered read of the variable file and the response register.
// Reset is synchronous; request words are refused until a register has recorded its end.
// Either side may stall; the two-entry queue and the response register decouple them.
module register_ir_execute_unit import rirx_pkg::*; #(
   parameter int NUM_VARS   = DEF_NUM_VARS,
   parameter int PROG_DEPTH = DEF_PROG_DEPTH,
   localparam int PC_W       = $clog2(PROG_DEPTH + 1),
   localparam int RSP_DATA_W = ((PC_W + VALUE_W + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // dest_index, src_a_index, src_b_index, immediate, target_index
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // action
   input  logic [ACTION_W-1:0]   req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // next_pc, out_value
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // out_valid, status
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   logic    q_full;
   logic    q_push;
   dec_type q_word;
   logic    q_pop;
   logic    q_head_valid;
   dec_type q_head_word;

   rirx_front #(
      .NUM_VARS (NUM_VARS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_word     (q_word)
   );

   rirx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_word  (q_word),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_word  (q_head_word)
   );

   rirx_back #(
      .NUM_VARS   (NUM_VARS),
      .PROG_DEPTH (PROG_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_word  (q_head_word),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== hdl/rirx_front.sv =====
// Front end: accepts request words and classifies each instruction.
module rirx_front import rirx_pkg::*; #(
   parameter int NUM_VARS = DEF_NUM_VARS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [ACTION_W-1:0]   req_tuser,
   input  logic                  q_full,
   output logic                  q_push,
   output dec_type               q_word
);

   localparam int DEST_LSB = 0;
   localparam int A_LSB    = DEST_LSB + RAW_IDX_W;
   localparam int B_LSB    = A_LSB + RAW_IDX_W;
   localparam int IMM_LSB  = B_LSB + RAW_IDX_W;
   localparam int TGT_LSB  = IMM_LSB + VALUE_W;

   logic [VAR_IDX_W-1:0] mod_lut [2**RAW_IDX_W];
   logic [RAW_IDX_W-1:0] raw_d;
   logic [RAW_IDX_W-1:0] raw_a;
   logic [RAW_IDX_W-1:0] raw_b;
   logic                 seen_reset_ff;
   logic                 seen_reset_in;

   always_comb begin
      for (int i = 0; i < 2**RAW_IDX_W; i++) begin
         mod_lut[i] = VAR_IDX_W'(i % NUM_VARS);
      end
   end

   assign seen_reset_in = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_reset_ff <= 1'b0;
      end else begin
         seen_reset_ff <= seen_reset_in;
      end
   end

   assign req_tready = !q_full && seen_reset_ff;
   assign q_push     = req_tvalid && req_tready;

   assign raw_d = req_tdata[DEST_LSB +: RAW_IDX_W];
   assign raw_a = req_tdata[A_LSB +: RAW_IDX_W];
   assign raw_b = req_tdata[B_LSB +: RAW_IDX_W];

   always_comb begin
      q_word          = '0;
      q_word.wsel     = WR_IMM;
      q_word.dest     = mod_lut[raw_d];
      q_word.src_a    = mod_lut[raw_a];
      q_word.src_b    = mod_lut[raw_b];
      q_word.imm      = req_tdata[IMM_LSB +: VALUE_W];
      q_word.target   = req_tdata[TGT_LSB +: TARGET_W];
      unique case (op_type'(req_tuser))
         OP_LDCONST, OP_STCONST: begin
            q_word.wr_dest = 1'b1;
            q_word.wsel    = WR_IMM;
         end
         OP_LDVAR, OP_STORE: begin
            q_word.need_a  = 1'b1;
            q_word.wr_dest = 1'b1;
            q_word.wsel    = WR_COPY;
         end
         OP_ADD: begin
            q_word.need_a  = 1'b1;
            q_word.need_b  = 1'b1;
            q_word.wr_dest = 1'b1;
            q_word.wsel    = WR_ADD;
         end
         OP_SUB: begin
            q_word.need_a  = 1'b1;
            q_word.need_b  = 1'b1;
            q_word.wr_dest = 1'b1;
            q_word.wsel    = WR_SUB;
         end
         OP_OUT: begin
            q_word.need_a = 1'b1;
            q_word.is_out = 1'b1;
         end
         OP_HALT: begin
            q_word.is_halt = 1'b1;
         end
         OP_GOTO: begin
            q_word.is_goto = 1'b1;
         end
         OP_IFLEQ: begin
            q_word.is_ifleq = 1'b1;
         end
         OP_LABEL: begin
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== hdl/rirx_queue.sv =====
// Short queue of classified instructions between front and back end.
module rirx_queue import rirx_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  dec_type push_word,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output dec_type head_word
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   dec_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               do_push;
   logic               do_pop;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_word  = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ===== hdl/rirx_back.sv =====
// Back end: variable file read, execute, state update and response register.
module rirx_back import rirx_pkg::*; #(
   parameter int NUM_VARS   = DEF_NUM_VARS,
   parameter int PROG_DEPTH = DEF_PROG_DEPTH,
   localparam int PC_W       = $clog2(PROG_DEPTH + 1),
   localparam int RSP_DATA_W = ((PC_W + VALUE_W + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  dec_type               head_word,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   localparam int VAR_W = $clog2(NUM_VARS);
   localparam int SUM_W = ((PC_W > TARGET_W) ? PC_W : TARGET_W) + 1;

   logic [VALUE_W-1:0]  value_mem [NUM_VARS];
   logic [NUM_VARS-1:0] defined_ff;
   logic [NUM_VARS-1:0] defined_in;
   logic [NUM_VARS-1:0] written_ff;
   logic [NUM_VARS-1:0] written_in;
   logic                e_valid_ff;
   dec_type             e_word_ff;
   logic [VALUE_W-1:0]  ra_ff;
   logic [VALUE_W-1:0]  rb_ff;
   logic [PC_W-1:0]     pc_ff;
   logic [PC_W-1:0]     pc_in;
   logic                stopped_ff;
   logic                stopped_in;
   logic                rsp_valid_ff;
   logic [PC_W-1:0]     rsp_pc_ff;
   logic                rsp_ov_ff;
   logic [VALUE_W-1:0]  rsp_value_ff;
   status_type          rsp_status_ff;
   logic [VALUE_W-1:0]  value_in;
   logic                ov_in;
   status_type          status_in;

   logic [VAR_W-1:0]    e_d;
   logic [VAR_W-1:0]    e_a;
   logic [VAR_W-1:0]    e_b;
   logic [VAR_W-1:0]    h_a;
   logic [VAR_W-1:0]    h_b;
   logic [VALUE_W-1:0]  va;
   logic [VALUE_W-1:0]  vb;
   logic [VALUE_W-1:0]  wdata;
   logic [SUM_W-1:0]    pc_inc;
   logic [SUM_W-1:0]    tgt_inc;
   logic [PC_W-1:0]     pc_seq;
   logic [PC_W-1:0]     pc_jump;
   logic                undef;
   logic                leq;
   logic                wr_en;
   logic                wr_fire;
   logic                advance;

   assign e_d = e_word_ff.dest[VAR_W-1:0];
   assign e_a = e_word_ff.src_a[VAR_W-1:0];
   assign e_b = e_word_ff.src_b[VAR_W-1:0];
   assign h_a = head_word.src_a[VAR_W-1:0];
   assign h_b = head_word.src_b[VAR_W-1:0];

   assign advance = e_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign pop     = head_valid && (!e_valid_ff || advance);

   assign va    = written_ff[e_a] ? ra_ff : '0;
   assign vb    = written_ff[e_b] ? rb_ff : '0;
   assign undef = (e_word_ff.need_a && !defined_ff[e_a]) ||
                  (e_word_ff.need_b && !defined_ff[e_b]);
   assign leq   = $signed(va) <= $signed(vb);

   assign pc_inc  = SUM_W'(pc_ff) + 1'b1;
   assign tgt_inc = SUM_W'(e_word_ff.target) + 1'b1;
   assign pc_seq  = (pc_inc > SUM_W'(PROG_DEPTH)) ? PC_W'(PROG_DEPTH) : pc_inc[PC_W-1:0];
   assign pc_jump = (tgt_inc > SUM_W'(PROG_DEPTH)) ? PC_W'(PROG_DEPTH) : tgt_inc[PC_W-1:0];

   always_comb begin
      unique case (e_word_ff.wsel)
         WR_IMM:  wdata = e_word_ff.imm;
         WR_COPY: wdata = va;
         WR_ADD:  wdata = va + vb;
         WR_SUB:  wdata = va - vb;
         default: wdata = e_word_ff.imm;
      endcase
   end

   always_comb begin
      pc_in      = pc_seq;
      stopped_in = stopped_ff;
      defined_in = defined_ff;
      written_in = written_ff;
      status_in  = ST_OK;
      ov_in      = 1'b0;
      value_in   = '0;
      wr_en      = 1'b0;
      priority if (stopped_ff) begin
         status_in = ST_STOPPED;
         pc_in     = pc_ff;
      end else if (undef) begin
         status_in  = ST_UNDEF;
         stopped_in = 1'b1;
         pc_in      = pc_ff;
      end else begin
         if (e_word_ff.wr_dest) begin
            wr_en           = 1'b1;
            defined_in[e_d] = 1'b1;
            written_in[e_d] = 1'b1;
         end
         if (e_word_ff.is_out) begin
            ov_in    = 1'b1;
            value_in = va;
         end
         if (e_word_ff.is_halt) begin
            status_in  = ST_HALT;
            stopped_in = 1'b1;
            pc_in      = pc_ff;
         end
         if (e_word_ff.is_goto) begin
            pc_in = pc_jump;
         end
         if (e_word_ff.is_ifleq) begin
            defined_in[e_a] = 1'b1;
            defined_in[e_b] = 1'b1;
            if (leq) begin
               pc_in = pc_jump;
            end
         end
      end
   end

   assign wr_fire = advance && wr_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff   <= 1'b0;
         pc_ff        <= '0;
         stopped_ff   <= 1'b0;
         defined_ff   <= '0;
         written_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            e_valid_ff <= 1'b1;
         end else if (advance) begin
            e_valid_ff <= 1'b0;
         end
         if (advance) begin
            pc_ff      <= pc_in;
            stopped_ff <= stopped_in;
            defined_ff <= defined_in;
            written_ff <= written_in;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         e_word_ff <= head_word;
         ra_ff     <= (wr_fire && (e_d == h_a)) ? wdata : value_mem[h_a];
         rb_ff     <= (wr_fire && (e_d == h_b)) ? wdata : value_mem[h_b];
      end
      if (advance) begin
         rsp_pc_ff     <= pc_in;
         rsp_ov_ff     <= ov_in;
         rsp_value_ff  <= value_in;
         rsp_status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_fire) begin
         value_mem[e_d] <= wdata;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_value_ff, rsp_pc_ff});
   assign rsp_tuser  = {rsp_status_ff, rsp_ov_ff};

endmodule

// ===== hdl/rirx_checker.sv =====
// Port-level checks for the register IR execute unit and their binding.
module rirx_checker import rirx_pkg::*; #(
   parameter int NUM_VARS   = DEF_NUM_VARS,
   parameter int PROG_DEPTH = DEF_PROG_DEPTH,
   localparam int PC_W       = $clog2(PROG_DEPTH + 1),
   localparam int RSP_DATA_W = ((PC_W + VALUE_W + 7) / 8) * 8
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic [ACTION_W-1:0]   req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser
);

   localparam int VAR_COUNT = NUM_VARS;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response word changed while stalled");

   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[PC_W +: VALUE_W] == '0)
      else $error("output value not zero without an output");

   a_out_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tuser[2:1] == ST_OK)
      else $error("output produced with a non-ok status");

   a_pc_range: assert property (@(posedge clock) disable iff (reset || VAR_COUNT < 2)
      rsp_tvalid |-> rsp_tdata[PC_W-1:0] <= PC_W'(PROG_DEPTH))
      else $error("next program counter beyond program end");

   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid && !req_tready)
      else $error("handshake active straight after reset");

endmodule

bind register_ir_execute_unit rirx_checker #(
   .NUM_VARS   (NUM_VARS),
   .PROG_DEPTH (PROG_DEPTH)
) u_rirx_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/register_ir_execute_unit_tb.sv =====
// Self-checking testbench for the register IR execute unit with a predicting monitor.
`timescale 1ns / 1ps

module register_ir_execute_unit_tb;
   import rirx_pkg::*;

   localparam int NUM_VARS   = DEF_NUM_VARS;
   localparam int PROG_DEPTH = DEF_PROG_DEPTH;
   localparam int PC_W       = $clog2(PROG_DEPTH + 1);
   localparam int RSP_DATA_W = ((PC_W + VALUE_W + 7) / 8) * 8;
   localparam logic [4:0] SPARE_VAR = 5'd13;
   localparam int PHASE_WORDS = 262;

   typedef struct {
      logic [ACTION_W-1:0] action;
      logic [4:0]          dest;
      logic [4:0]          src_a;
      logic [4:0]          src_b;
      logic [VALUE_W-1:0]  imm;
      logic [TARGET_W-1:0] target;
   } ir_word_type;

   typedef struct {
      logic [PC_W-1:0]    next_pc;
      logic               out_valid;
      logic [VALUE_W-1:0] out_value;
      status_type         status;
   } pc_outcome_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [ACTION_W-1:0]   req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   ir_word_type    ir_pending[$];
   pc_outcome_type outcome_queue[$];
   ir_word_type    req_word;
   logic           req_taken = 1'b0;
   int             words_queued = 0;
   int             words_accepted = 0;
   int             fail_count = 0;
   int             send_idle_pct = 0;
   int             recv_stall_pct = 0;
   logic [31:0]    gen_defined = '0;

   logic [VALUE_W-1:0] shadow_value[NUM_VARS];
   logic               shadow_defined[NUM_VARS];
   logic [PC_W-1:0]    shadow_pc = '0;
   logic               shadow_stopped = 1'b0;

   register_ir_execute_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < NUM_VARS; i++) begin
         shadow_value[i]   = '0;
         shadow_defined[i] = 1'b0;
      end
   end

   function automatic logic [PC_W-1:0] clamp_pc(input logic [PC_W:0] v);
      return (v > PROG_DEPTH) ? PC_W'(PROG_DEPTH) : v[PC_W-1:0];
   endfunction

   task automatic execute_ir(input ir_word_type w, output pc_outcome_type r);
      logic need_a;
      logic need_b;
      r.next_pc   = clamp_pc({1'b0, shadow_pc} + 1'b1);
      r.out_valid = 1'b0;
      r.out_value = '0;
      r.status    = ST_OK;
      if (shadow_stopped) begin
         r.status  = ST_STOPPED;
         r.next_pc = shadow_pc;
      end else begin
         need_a = w.action inside {OP_LDVAR, OP_ADD, OP_SUB, OP_STORE, OP_OUT};
         need_b = w.action inside {OP_ADD, OP_SUB};
         if ((need_a && !shadow_defined[w.src_a]) || (need_b && !shadow_defined[w.src_b])) begin
            r.status       = ST_UNDEF;
            shadow_stopped = 1'b1;
            r.next_pc      = shadow_pc;
         end else begin
            case (w.action)
               OP_LDCONST, OP_STCONST: begin
                  shadow_value[w.dest]   = w.imm;
                  shadow_defined[w.dest] = 1'b1;
               end
               OP_LDVAR, OP_STORE: begin
                  shadow_value[w.dest]   = shadow_value[w.src_a];
                  shadow_defined[w.dest] = 1'b1;
               end
               OP_ADD: begin
                  shadow_value[w.dest]   = shadow_value[w.src_a] + shadow_value[w.src_b];
                  shadow_defined[w.dest] = 1'b1;
               end
               OP_SUB: begin
                  shadow_value[w.dest]   = shadow_value[w.src_a] - shadow_value[w.src_b];
                  shadow_defined[w.dest] = 1'b1;
               end
               OP_OUT: begin
                  r.out_valid = 1'b1;
                  r.out_value = shadow_value[w.src_a];
               end
               OP_HALT: begin
                  r.status       = ST_HALT;
                  shadow_stopped = 1'b1;
                  r.next_pc      = shadow_pc;
               end
               OP_GOTO: begin
                  r.next_pc = clamp_pc({1'b0, w.target} + 1'b1);
               end
               OP_IFLEQ: begin
                  if (!shadow_defined[w.src_a]) begin
                     shadow_value[w.src_a]   = '0;
                     shadow_defined[w.src_a] = 1'b1;
                  end
                  if (!shadow_defined[w.src_b]) begin
                     shadow_value[w.src_b]   = '0;
                     shadow_defined[w.src_b] = 1'b1;
                  end
                  if ($signed(shadow_value[w.src_a]) <= $signed(shadow_value[w.src_b]))
                     r.next_pc = clamp_pc({1'b0, w.target} + 1'b1);
               end
               default: begin
               end
            endcase
         end
      end
      shadow_pc = r.next_pc;
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (ir_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_word = ir_pending.pop_front();
            req_tdata <= {1'b0, req_word.target, req_word.imm, req_word.src_b,
                          req_word.src_a, req_word.dest};
            req_tuser  <= req_word.action;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      pc_outcome_type predicted;
      pc_outcome_type oldest;
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            execute_ir(req_word, predicted);
            outcome_queue.push_back(predicted);
            words_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (outcome_queue.size() == 0) begin
               $error("response word with no expectation waiting");
               fail_count++;
            end else begin
               oldest = outcome_queue.pop_front();
               if (rsp_tdata[PC_W-1:0] !== oldest.next_pc) begin
                  $error("next_pc: expected %0d, actual %0d", oldest.next_pc,
                         rsp_tdata[PC_W-1:0]);
                  fail_count++;
               end
               if (rsp_tdata[PC_W +: VALUE_W] !== oldest.out_value) begin
                  $error("out_value: expected %h, actual %h", oldest.out_value,
                         rsp_tdata[PC_W +: VALUE_W]);
                  fail_count++;
               end
               if (rsp_tuser[0] !== oldest.out_valid) begin
                  $error("out_valid: expected %0d, actual %0d", oldest.out_valid, rsp_tuser[0]);
                  fail_count++;
               end
               if (rsp_tuser[2:1] !== oldest.status) begin
                  $error("status: expected %0d, actual %0d", oldest.status, rsp_tuser[2:1]);
                  fail_count++;
               end
            end
         end
      end
   end

   function automatic logic [4:0] open_index();
      logic [4:0] idx;
      do idx = 5'($urandom_range(31)); while (idx == SPARE_VAR);
      return idx;
   endfunction

   function automatic logic [4:0] defined_index();
      logic [4:0] idx;
      do idx = 5'($urandom_range(31)); while (!gen_defined[idx]);
      return idx;
   endfunction

   function automatic logic [4:0] any5();
      return 5'($urandom_range(31));
   endfunction

   function automatic logic [TARGET_W-1:0] any_target();
      return ($urandom_range(7) == 0) ? 8'hFF : 8'($urandom_range(255));
   endfunction

   function automatic logic [VALUE_W-1:0] random_imm();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         4: return 32'($urandom_range(15));
         5: return -32'($urandom_range(16));
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_word(input logic [ACTION_W-1:0] action, input logic [4:0] dest,
                             input logic [4:0] src_a, input logic [4:0] src_b,
                             input logic [VALUE_W-1:0] imm, input logic [TARGET_W-1:0] target);
      ir_word_type w;
      w.action = action;
      w.dest   = dest;
      w.src_a  = src_a;
      w.src_b  = src_b;
      w.imm    = imm;
      w.target = target;
      if (action inside {OP_LDCONST, OP_LDVAR, OP_ADD, OP_SUB, OP_STORE, OP_STCONST})
         gen_defined[dest] = 1'b1;
      if (action == OP_IFLEQ) begin
         gen_defined[src_a] = 1'b1;
         gen_defined[src_b] = 1'b1;
      end
      ir_pending.push_back(w);
      words_queued++;
   endtask

   task automatic random_word();
      int r;
      r = $urandom_range(99);
      if (r < 15)
         queue_word(OP_LDCONST, open_index(), any5(), any5(), random_imm(), any_target());
      else if (r < 23)
         queue_word(OP_STCONST, open_index(), any5(), any5(), random_imm(), any_target());
      else if (r < 33)
         queue_word(r[0] ? OP_LDVAR : OP_STORE, open_index(), defined_index(), any5(),
                    $urandom, any_target());
      else if (r < 48)
         queue_word(OP_ADD, open_index(), defined_index(), defined_index(), $urandom,
                    any_target());
      else if (r < 58)
         queue_word(OP_SUB, open_index(), defined_index(), defined_index(), $urandom,
                    any_target());
      else if (r < 70)
         queue_word(OP_OUT, any5(), defined_index(), any5(), $urandom, any_target());
      else if (r < 75)
         queue_word(OP_LABEL, any5(), any5(), any5(), $urandom, any_target());
      else if (r < 83)
         queue_word(OP_GOTO, any5(), any5(), any5(), $urandom, any_target());
      else if (r < 95)
         queue_word(OP_IFLEQ, any5(), open_index(), open_index(), $urandom, any_target());
      else
         queue_word(4'($urandom_range(11, 15)), any5(), any5(), any5(), $urandom,
                    any_target());
   endtask

   task automatic wait_drained();
      while (words_accepted != words_queued) @(negedge clock);
   endtask

   initial begin
      int guard;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Branch on two never-written variables, which reads them as zero and defines them.
      queue_word(OP_IFLEQ, 5'd0, 5'd3, 5'd7, 32'h0, 8'd10);
      queue_word(OP_OUT, 5'd0, 5'd3, 5'd0, 32'h0, 8'd0);
      queue_word(OP_LDCONST, 5'd0, 5'd0, 5'd0, 32'h7FFF_FFFF, 8'd0);
      queue_word(OP_LDCONST, 5'd1, 5'd0, 5'd0, 32'h0000_0001, 8'd0);
      queue_word(OP_ADD, 5'd2, 5'd0, 5'd1, 32'h0, 8'd0);
      queue_word(OP_STCONST, 5'd31, 5'd0, 5'd0, 32'h8000_0000, 8'd0);
      queue_word(OP_SUB, 5'd30, 5'd31, 5'd1, 32'h0, 8'd0);
      queue_word(OP_LDVAR, 5'd4, 5'd2, 5'd0, 32'h0, 8'd0);
      queue_word(OP_STORE, 5'd5, 5'd30, 5'd0, 32'h0, 8'd0);
      queue_word(OP_OUT, 5'd0, 5'd2, 5'd0, 32'h0, 8'd0);
      queue_word(OP_OUT, 5'd0, 5'd31, 5'd0, 32'h0, 8'd0);
      queue_word(OP_LABEL, 5'd0, 5'd0, 5'd0, 32'h0, 8'd0);
      queue_word(4'd15, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF, 8'hFF);
      queue_word(4'd11, 5'd0, 5'd0, 5'd0, 32'h0, 8'd0);
      queue_word(OP_GOTO, 5'd0, 5'd0, 5'd0, 32'h0, 8'hFF);
      queue_word(OP_LABEL, 5'd0, 5'd0, 5'd0, 32'h0, 8'd0);
      queue_word(OP_GOTO, 5'd0, 5'd0, 5'd0, 32'h0, 8'd0);
      queue_word(OP_IFLEQ, 5'd0, 5'd0, 5'd1, 32'h0, 8'd40);
      queue_word(OP_IFLEQ, 5'd0, 5'd31, 5'd0, 32'h0, 8'd128);
      queue_word(OP_IFLEQ, 5'd0, 5'd0, 5'd0, 32'h0, 8'd254);
      queue_word(OP_STCONST, 5'd29, 5'd0, 5'd0, 32'hFFFF_FFFF, 8'd0);
      queue_word(OP_SUB, 5'd28, 5'd29, 5'd29, 32'h0, 8'd0);
      queue_word(OP_ADD, 5'd27, 5'd29, 5'd29, 32'h0, 8'd0);
      queue_word(OP_OUT, 5'd0, 5'd27, 5'd0, 32'h0, 8'd0);
      queue_word(OP_OUT, 5'd0, 5'd28, 5'd0, 32'h0, 8'd0);

      repeat (PHASE_WORDS) random_word();
      wait_drained();
      send_idle_pct = 84;
      repeat (PHASE_WORDS) random_word();
      wait_drained();
      send_idle_pct  = 0;
      recv_stall_pct = 84;
      repeat (PHASE_WORDS) random_word();
      wait_drained();
      send_idle_pct  = 16;
      recv_stall_pct = 16;
      repeat (PHASE_WORDS) random_word();

      // The block stops for good, either on a halt or on reading the variable never written.
      if ($urandom_range(1)) begin
         queue_word(OP_HALT, any5(), any5(), any5(), $urandom, any_target());
      end else begin
         case ($urandom_range(2))
            0: queue_word(OP_OUT, any5(), SPARE_VAR, any5(), $urandom, any_target());
            1: queue_word(OP_ADD, open_index(), defined_index(), SPARE_VAR, $urandom,
                          any_target());
            default: queue_word(OP_LDVAR, open_index(), SPARE_VAR, any5(), $urandom,
                                any_target());
         endcase
      end
      queue_word(OP_HALT, any5(), any5(), any5(), $urandom, any_target());
      repeat (6) random_word();

      wait_drained();
      guard = 0;
      while (outcome_queue.size() != 0 && guard < 10000) begin
         @(negedge clock);
         guard++;
      end
      repeat (10) @(negedge clock);
      if (outcome_queue.size() != 0) begin
         $error("%0d expected response words never arrived", outcome_queue.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("register_ir_execute_unit_tb passed");
      else
         $display("register_ir_execute_unit_tb failed");
      $finish;
   end

   initial begin
      #2ms;
      $display("register_ir_execute_unit_tb failed");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/rirx_pkg.sv
hdl/rirx_front.sv
hdl/rirx_queue.sv
hdl/rirx_back.sv
hdl/register_ir_execute_unit.sv
hdl/rirx_checker.sv
tb/register_ir_execute_unit_tb.sv
